[src/tcw_pkg.sv]
`default_nettype none

package tcw_pkg;

    // screen geometry defaults
    localparam int DEF_SCREEN_ROWS    = 25;
    localparam int DEF_SCREEN_COLUMNS = 80;

    // field widths
    localparam int ACTION_W = 2;
    localparam int CHAR_W   = 8;
    localparam int ATTR_W   = 8;
    localparam int ROW_W    = 5;
    localparam int COLUMN_W = 7;
    localparam int OFFSET_W = 11;
    localparam int CELL_W   = CHAR_W + ATTR_W;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_FILL  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;

    // character and attribute constants
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE     = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_FIRST_PRINT = 8'd32;
    localparam logic [ATTR_W-1:0] CURSOR_FG        = 8'h07;
    localparam logic [ATTR_W-1:0] BG_MASK          = 8'hF0;
    localparam logic [ATTR_W-1:0] TEXT_ATTR_RESET  = 8'd15;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [CHAR_W-1:0]   char_code;
        logic [ATTR_W-1:0]   fill_attr;
        logic [ROW_W-1:0]    cell_row;
        logic [COLUMN_W-1:0] cell_column;
    } tcw_in_t;

    typedef struct packed {
        logic [ROW_W-1:0]    cursor_row;
        logic [COLUMN_W-1:0] cursor_column;
        logic [OFFSET_W-1:0] cursor_offset;
        logic [CHAR_W-1:0]   cell_char;
        logic [ATTR_W-1:0]   cell_attr;
    } tcw_out_t;

endpackage

`default_nettype wire

[src/text_console_writer.sv]
`default_nettype none

// Text console engine: a screen store of SCREEN_ROWS x SCREEN_COLUMNS cells
// (character in the low byte, attribute in the high byte) in one memory with
// one write and one registered read port, plus a cursor. Items are handled one
// at a time by a small sequencer that drives a single row*columns+column
// address unit, shared by cell addressing and the reported cursor offset.
// A fill walks the store at one cell per cycle, and a write that scrolls
// adds one more pass over the store, one copied cell per cycle through the
// memory's read-then-write path. After reset all rows*columns cells (2000 by
// default) are cleared by a fill pass, during which s_ready stays low;
// configuration writes are taken at any time. A finished result waits in an
// output register while the next item is taken.
module text_console_writer #(
    parameter int SCREEN_ROWS    = tcw_pkg::DEF_SCREEN_ROWS,
    parameter int SCREEN_COLUMNS = tcw_pkg::DEF_SCREEN_COLUMNS
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire tcw_pkg::tcw_in_t        s_data,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output tcw_pkg::tcw_out_t            m_data,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [tcw_pkg::ATTR_W-1:0] cfg_data
);
    import tcw_pkg::*;

    localparam int CELLS   = SCREEN_ROWS * SCREEN_COLUMNS;
    localparam int RPOS_W  = $clog2(SCREEN_ROWS);
    localparam int CPOS_W  = $clog2(SCREEN_COLUMNS);
    localparam int ADDR_W  = $clog2(CELLS);

    localparam logic [RPOS_W-1:0] LAST_ROW    = RPOS_W'(SCREEN_ROWS - 1);
    localparam logic [CPOS_W-1:0] LAST_COLUMN = CPOS_W'(SCREEN_COLUMNS - 1);
    localparam logic [ADDR_W-1:0] LAST_CELL   = ADDR_W'(CELLS - 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_ADDR   = 4'd1;
    localparam logic [3:0] S_PUT    = 4'd2;
    localparam logic [3:0] S_SCROLL = 4'd3;
    localparam logic [3:0] S_CADDR  = 4'd4;
    localparam logic [3:0] S_CRD    = 4'd5;
    localparam logic [3:0] S_CWR    = 4'd6;
    localparam logic [3:0] S_FILL   = 4'd7;
    localparam logic [3:0] S_RRD    = 4'd8;
    localparam logic [3:0] S_RCAP   = 4'd9;
    localparam logic [3:0] S_DONE   = 4'd10;

    logic [3:0]        state_reg, state_next;
    logic [RPOS_W-1:0] row_reg, row_next;
    logic [CPOS_W-1:0] col_reg, col_next;
    logic [ADDR_W-1:0] ptr_reg, ptr_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    tcw_in_t           in_reg, in_next;
    logic              clr_reg, clr_next;
    logic [CELL_W-1:0] cell_reg, cell_next;
    logic              wr_pend_reg, wr_pend_next;
    logic [ADDR_W-1:0] wr_dst_reg, wr_dst_next;
    logic              wr_zero_reg, wr_zero_next;
    logic              m_valid_reg, m_valid_next;
    tcw_out_t          m_data_reg, m_data_next;
    logic [ATTR_W-1:0] text_attr_reg, text_attr_next;

    // screen store
    logic [CELL_W-1:0] mem [CELLS];
    logic [CELL_W-1:0] rd_data_reg;
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [CELL_W-1:0] mem_wdata;
    logic              state_we;

    // shared address unit
    logic [RPOS_W-1:0] mul_row;
    logic [CPOS_W-1:0] mul_col;
    logic [ADDR_W-1:0] mul_res;

    logic              s_fire, out_free, rd_in_range, printable;
    logic [ADDR_W:0]   src_wide;
    logic              src_ok;
    logic [ATTR_W-1:0] cursor_attr;

    assign s_ready   = (state_reg == S_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign out_free  = !m_valid_reg || m_ready;

    assign rd_in_range = (32'(in_reg.cell_row) < SCREEN_ROWS)
                      && (32'(in_reg.cell_column) < SCREEN_COLUMNS);
    assign printable   = (in_reg.char_code >= CHAR_FIRST_PRINT) && !in_reg.char_code[CHAR_W-1];
    assign cursor_attr = CURSOR_FG | (text_attr_reg & BG_MASK);

    // scroll copies cell dst+columns into dst, zero past the end
    assign src_wide = {1'b0, ptr_reg} + (ADDR_W+1)'(SCREEN_COLUMNS);
    assign src_ok   = src_wide < (ADDR_W+1)'(CELLS);

    always_comb begin
        if (state_reg == S_ADDR && in_reg.action == ACT_READ && rd_in_range) begin
            mul_row = RPOS_W'(in_reg.cell_row);
            mul_col = CPOS_W'(in_reg.cell_column);
        end else begin
            mul_row = row_reg;
            mul_col = col_reg;
        end
        mul_res = ADDR_W'(mul_row) * ADDR_W'(SCREEN_COLUMNS) + ADDR_W'(mul_col);
    end

    // memory port control
    always_comb begin
        state_we  = (state_reg == S_PUT) || (state_reg == S_CWR) || (state_reg == S_FILL);
        mem_we    = 1'b0;
        mem_waddr = addr_reg;
        mem_wdata = '0;
        priority if (wr_pend_reg) begin
            mem_we    = 1'b1;
            mem_waddr = wr_dst_reg;
            mem_wdata = wr_zero_reg ? '0 : rd_data_reg;
        end else if (state_reg == S_PUT) begin
            mem_we    = 1'b1;
            mem_wdata = {text_attr_reg, in_reg.char_code};
        end else if (state_reg == S_CWR) begin
            mem_we    = 1'b1;
            mem_wdata = {cursor_attr, rd_data_reg[CHAR_W-1:0]};
        end else if (state_reg == S_FILL) begin
            mem_we    = 1'b1;
            mem_waddr = ptr_reg;
            mem_wdata = clr_reg ? '0 : {in_reg.fill_attr, in_reg.char_code};
        end else begin
            mem_we    = 1'b0;
        end

        mem_re    = 1'b0;
        mem_raddr = addr_reg;
        if (state_reg == S_SCROLL) begin
            mem_re    = src_ok;
            mem_raddr = ADDR_W'(src_wide);
        end else if (state_reg == S_CRD || state_reg == S_RRD) begin
            mem_re    = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    // sequencer
    always_comb begin
        state_next     = state_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        ptr_next       = ptr_reg;
        addr_next      = addr_reg;
        in_next        = in_reg;
        clr_next       = clr_reg;
        cell_next      = cell_reg;
        wr_pend_next   = 1'b0;
        wr_dst_next    = wr_dst_reg;
        wr_zero_next   = wr_zero_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        text_attr_next = cfg_valid ? cfg_data : text_attr_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    in_next    = s_data;
                    cell_next  = '0;
                    state_next = S_ADDR;
                end
            end
            S_ADDR: begin
                addr_next = mul_res;
                ptr_next  = '0;
                unique case (in_reg.action)
                    ACT_WRITE: begin
                        if (in_reg.char_code == CHAR_NEWLINE) begin
                            col_next = '0;
                            if (row_reg == LAST_ROW) begin
                                state_next = S_SCROLL;
                            end else begin
                                row_next   = row_reg + 1'b1;
                                state_next = S_CADDR;
                            end
                        end else if (printable) begin
                            state_next = S_PUT;
                        end else begin
                            state_next = S_CRD;
                        end
                    end
                    ACT_FILL: state_next = S_FILL;
                    ACT_READ: state_next = rd_in_range ? S_RRD : S_DONE;
                    default:  state_next = S_DONE;
                endcase
            end
            S_PUT: begin
                if (col_reg != LAST_COLUMN) begin
                    col_next   = col_reg + 1'b1;
                    state_next = S_CADDR;
                end else begin
                    col_next = '0;
                    if (row_reg == LAST_ROW) begin
                        state_next = S_SCROLL;
                    end else begin
                        row_next   = row_reg + 1'b1;
                        state_next = S_CADDR;
                    end
                end
            end
            S_SCROLL: begin
                wr_pend_next = 1'b1;
                wr_dst_next  = ptr_reg;
                wr_zero_next = !src_ok;
                ptr_next     = ptr_reg + 1'b1;
                if (ptr_reg == LAST_CELL) begin
                    state_next = S_CADDR;
                end
            end
            S_CADDR: begin
                addr_next  = mul_res;
                state_next = S_CRD;
            end
            S_CRD:  state_next = S_CWR;
            S_CWR:  state_next = S_DONE;
            S_FILL: begin
                ptr_next = ptr_reg + 1'b1;
                if (ptr_reg == LAST_CELL) begin
                    row_next   = '0;
                    col_next   = '0;
                    clr_next   = 1'b0;
                    state_next = clr_reg ? S_IDLE : S_DONE;
                end
            end
            S_RRD:  state_next = S_RCAP;
            S_RCAP: begin
                cell_next  = rd_data_reg;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next.cursor_row    = ROW_W'(32'(row_reg));
                    m_data_next.cursor_column = COLUMN_W'(32'(col_reg));
                    m_data_next.cursor_offset = OFFSET_W'(32'(mul_res));
                    m_data_next.cell_char     = cell_reg[CHAR_W-1:0];
                    m_data_next.cell_attr     = cell_reg[CELL_W-1:CHAR_W];
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_FILL;
            row_reg       <= '0;
            col_reg       <= '0;
            ptr_reg       <= '0;
            clr_reg       <= 1'b1;
            wr_pend_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
            text_attr_reg <= TEXT_ATTR_RESET;
        end else begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            ptr_reg       <= ptr_next;
            clr_reg       <= clr_next;
            wr_pend_reg   <= wr_pend_next;
            m_valid_reg   <= m_valid_next;
            text_attr_reg <= text_attr_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg    <= addr_next;
        in_reg      <= in_next;
        cell_reg    <= cell_next;
        wr_dst_reg  <= wr_dst_next;
        wr_zero_reg <= wr_zero_next;
        m_data_reg  <= m_data_next;
    end

`ifndef NO_ASSERTIONS
    // a pending scroll write never meets a sequencer write
    a_write_port_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !(wr_pend_reg && state_we))
        else $error("scroll write collides with another store write");

    a_cursor_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (32'(row_reg) < SCREEN_ROWS) && (32'(col_reg) < SCREEN_COLUMNS))
        else $error("cursor outside the screen");

    a_one_item_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> !s_ready)
        else $error("new beat taken while an item is in work");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !$past(m_valid_reg && !m_ready)) |-> $past(state_reg == S_DONE))
        else $error("result beat raised outside the done step");
`endif

endmodule

`default_nettype wire

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import tcw_pkg::*;

    localparam int ROWS = DEF_SCREEN_ROWS;
    localparam int COLUMNS = DEF_SCREEN_COLUMNS;
    localparam int CELLS = ROWS * COLUMNS;
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam int IDLE_PCT = 22;
    localparam int HOLD_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int MAX_REPORTED = 10;
    localparam int SETTLE_CYCLES = 20;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    tcw_in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    tcw_out_t m_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [ATTR_W-1:0] cfg_data = '0;

    // mirror of the screen store, cursor and attribute register
    logic [CELL_W-1:0] screen_mem [CELLS];
    int cur_row = 0;
    int cur_col = 0;
    logic [ATTR_W-1:0] text_attr_q = TEXT_ATTR_RESET;

    tcw_out_t console_reports [$];
    int error_count = 0;
    int idle_cycles = 0;
    bit gaps_on = 1'b1;
    bit stall_on = 1'b1;
    bit hold_req = 1'b0;
    bit hold_seen = 1'b0;
    int hold_left = 0;

    always #4 aclk = ~aclk;

    text_console_writer #(
        .SCREEN_ROWS(ROWS),
        .SCREEN_COLUMNS(COLUMNS)
    ) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    function automatic void next_row();
        cur_row++;
        cur_col = 0;
        if (cur_row >= ROWS) begin
            // scroll up one row, bottom row goes blank
            for (int i = 0; i < CELLS - COLUMNS; i++) screen_mem[i] = screen_mem[i + COLUMNS];
            for (int i = CELLS - COLUMNS; i < CELLS; i++) screen_mem[i] = '0;
            cur_row = ROWS - 1;
        end
    endfunction

    function automatic int cursor_cell();
        int idx;
        idx = cur_row * COLUMNS + cur_col;
        return (idx < CELLS) ? idx : 0;
    endfunction

    function automatic tcw_out_t apply_console_action(input tcw_in_t item);
        tcw_out_t rep;
        int idx;
        rep = '0;
        case (item.action)
            ACT_WRITE: begin
                if (item.char_code == CHAR_NEWLINE) begin
                    next_row();
                end else if (item.char_code >= CHAR_FIRST_PRINT && !item.char_code[CHAR_W-1]) begin
                    // top bit set means a negative char, dropped like control codes
                    screen_mem[cursor_cell()] = {text_attr_q, item.char_code};
                    cur_col++;
                    if (cur_col >= COLUMNS) next_row();
                end
                idx = cursor_cell();
                screen_mem[idx][CELL_W-1:CHAR_W] = CURSOR_FG | (text_attr_q & BG_MASK);
            end
            ACT_FILL: begin
                for (int i = 0; i < CELLS; i++) screen_mem[i] = {item.fill_attr, item.char_code};
                cur_row = 0;
                cur_col = 0;
            end
            ACT_READ: begin
                if (item.cell_row < ROWS && item.cell_column < COLUMNS) begin
                    idx = item.cell_row * COLUMNS + item.cell_column;
                    {rep.cell_attr, rep.cell_char} = screen_mem[idx];
                end
            end
            default: begin
            end
        endcase
        rep.cursor_row = ROW_W'(cur_row);
        rep.cursor_column = COLUMN_W'(cur_col);
        rep.cursor_offset = OFFSET_W'(cur_row * COLUMNS + cur_col);
        return rep;
    endfunction

    function automatic tcw_in_t random_fields();
        tcw_in_t item;
        logic [31:0] r;
        r = $urandom;
        item.action = r[1:0];
        item.char_code = r[9:2];
        item.fill_attr = r[17:10];
        item.cell_row = r[22:18];
        item.cell_column = r[29:23];
        return item;
    endfunction

    function automatic tcw_in_t make_action(input logic [ACTION_W-1:0] action,
                                            input logic [CHAR_W-1:0] code,
                                            input logic [ATTR_W-1:0] fattr,
                                            input logic [ROW_W-1:0] row,
                                            input logic [COLUMN_W-1:0] col);
        tcw_in_t item;
        item.action = action;
        item.char_code = code;
        item.fill_attr = fattr;
        item.cell_row = row;
        item.cell_column = col;
        return item;
    endfunction

    // mostly running text with newlines, sprinkled with reads, junk codes and rare fills
    function automatic tcw_in_t pick_text_action();
        tcw_in_t item;
        int pick;
        item = random_fields();
        pick = $urandom_range(0, 999);
        if (pick < 600) begin
            item.action = ACT_WRITE;
            item.char_code = CHAR_W'($urandom_range(int'(CHAR_FIRST_PRINT), 127));
        end else if (pick < 750) begin
            item.action = ACT_WRITE;
            item.char_code = CHAR_NEWLINE;
        end else if (pick < 780) begin
            item.action = ACT_WRITE;
            item.char_code = CHAR_W'($urandom_range(0, int'(CHAR_FIRST_PRINT) - 1));
        end else if (pick < 810) begin
            item.action = ACT_WRITE;
            item.char_code = CHAR_W'($urandom_range(128, 255));
        end else if (pick < 880) begin
            item.action = ACT_READ;
            item.cell_row = ROW_W'($urandom_range(0, ROWS - 1));
            item.cell_column = COLUMN_W'($urandom_range(0, COLUMNS - 1));
        end else if (pick < 930) begin
            item.action = ACT_READ;
            item.cell_row = ROW_W'(cur_row);
            item.cell_column = COLUMN_W'(cur_col);
        end else if (pick < 960) begin
            item.action = ACT_READ;
        end else if (pick < 990) begin
            item.action = ACT_UNUSED;
        end else if (pick < 994) begin
            item.action = ACT_FILL;
        end else begin
            item.action = ACT_WRITE;
        end
        return item;
    endfunction

    task automatic send_action(input tcw_in_t item);
        while (gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= item;
        do @(posedge aclk); while (!s_ready);
        console_reports.push_back(apply_console_action(item));
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (console_reports.size() != 0) @(posedge aclk);
    endtask

    task automatic write_text_attr(input logic [ATTR_W-1:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        text_attr_q = value;
    endtask

    task automatic test_directed_cases();
        // fresh store reads back zero, out of range reads back zero
        send_action(make_action(ACT_READ, 8'h00, 8'h00, 5'd0, 7'd0));
        send_action(make_action(ACT_READ, 8'h00, 8'h00, ROW_W'(ROWS - 1), COLUMN_W'(COLUMNS - 1)));
        send_action(make_action(ACT_READ, 8'h00, 8'h00, ROW_W'(ROWS), 7'd0));
        send_action(make_action(ACT_READ, 8'h00, 8'h00, 5'd0, COLUMN_W'(COLUMNS)));
        send_action(make_action(ACT_READ, 8'hFF, 8'hFF, 5'h1F, 7'h7F));
        send_action(make_action(ACT_WRITE, 8'h41, 8'h00, 5'd0, 7'd0));
        send_action(make_action(ACT_WRITE, 8'h00, 8'h00, 5'd0, 7'd0));
        send_action(make_action(ACT_WRITE, CHAR_FIRST_PRINT - 1'b1, 8'h00, 5'd0, 7'd0));
        send_action(make_action(ACT_WRITE, 8'h80, 8'h00, 5'd0, 7'd0));
        send_action(make_action(ACT_WRITE, 8'hFF, 8'h00, 5'd0, 7'd0));
        send_action(make_action(ACT_WRITE, 8'h7F, 8'h00, 5'd0, 7'd0));
        send_action(make_action(ACT_WRITE, CHAR_FIRST_PRINT, 8'h00, 5'd0, 7'd0));
        send_action(make_action(ACT_WRITE, CHAR_NEWLINE, 8'h00, 5'd0, 7'd0));
        send_action(make_action(ACT_UNUSED, 8'hFF, 8'hFF, 5'h1F, 7'h7F));
        send_action(make_action(ACT_READ, 8'h00, 8'h00, 5'd0, 7'd0));
        send_action(make_action(ACT_READ, 8'h00, 8'h00, 5'd0, 7'd2));
        send_action(make_action(ACT_READ, 8'h00, 8'h00, 5'd1, 7'd0));
        send_action(make_action(ACT_FILL, 8'hFF, 8'h00, 5'd0, 7'd0));
        send_action(make_action(ACT_READ, 8'h00, 8'h00, ROW_W'(ROWS - 1), COLUMN_W'(COLUMNS - 1)));
        send_action(make_action(ACT_WRITE, CHAR_NEWLINE, 8'h00, 5'd0, 7'd0));
        send_action(make_action(ACT_FILL, 8'h00, 8'hFF, 5'd0, 7'd0));
        send_action(make_action(ACT_READ, 8'h00, 8'h00, 5'd12, 7'd40));
        send_action(make_action(ACT_WRITE, 8'h7A, 8'h00, 5'd0, 7'd0));
    endtask

    task automatic test_random_text(input logic [ATTR_W-1:0] attr, input int count);
        write_text_attr(attr);
        for (int n = 0; n < count; n++) send_action(pick_text_action());
    endtask

    task automatic test_back_to_back(input int count);
        write_text_attr(ATTR_W'($urandom));
        gaps_on = 1'b0;
        stall_on <= 1'b0;
        for (int n = 0; n < count; n++) send_action(pick_text_action());
        wait_drained();
        gaps_on = 1'b1;
        stall_on <= 1'b1;
    endtask

    task automatic test_backpressure();
        // receiver stops for a long stretch, sender keeps offering until input stalls
        hold_req <= ~hold_req;
        for (int n = 0; n < 40; n++) send_action(pick_text_action());
        wait_drained();
        for (int n = 0; n < 20; n++) send_action(pick_text_action());
    endtask

    always @(posedge aclk) begin
        hold_seen <= hold_req;
        if (hold_req != hold_seen) begin
            hold_left <= HOLD_CYCLES;
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else if (stall_on) begin
            m_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic report_mismatch(input tcw_out_t want, input tcw_out_t got, input bit orphan);
        error_count++;
        if (error_count <= MAX_REPORTED) begin
            if (orphan)
                $display("unexpected report beat: row %0d col %0d offset %0d char %02h attr %02h",
                         got.cursor_row, got.cursor_column, got.cursor_offset,
                         got.cell_char, got.cell_attr);
            else
                $display("report mismatch: expected row %0d col %0d offset %0d char %02h attr %02h, got row %0d col %0d offset %0d char %02h attr %02h",
                         want.cursor_row, want.cursor_column, want.cursor_offset,
                         want.cell_char, want.cell_attr,
                         got.cursor_row, got.cursor_column, got.cursor_offset,
                         got.cell_char, got.cell_attr);
        end
    endtask

    always @(posedge aclk) begin : check_reports
        tcw_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (console_reports.size() == 0) begin
                report_mismatch('0, m_data, 1'b1);
            end else begin
                want = console_reports.pop_front();
                if (m_data.cursor_row !== want.cursor_row
                        || m_data.cursor_column !== want.cursor_column
                        || m_data.cursor_offset !== want.cursor_offset
                        || m_data.cell_char !== want.cell_char
                        || m_data.cell_attr !== want.cell_attr)
                    report_mismatch(want, m_data, 1'b0);
            end
        end
    end

    // any accepted beat on any channel counts as progress
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_top: errors");
                $finish;
            end
        end
    end

    initial begin
        for (int i = 0; i < CELLS; i++) screen_mem[i] = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_cases();
        test_random_text(8'h00, 500);
        test_random_text(8'hFF, 500);
        test_back_to_back(200);
        test_backpressure();
        test_random_text(ATTR_W'($urandom), 400);
        test_random_text(8'hF0, 300);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (error_count == 0 && console_reports.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
